FILE: rtl/core/blpd_pkg.sv
// Shared types and constants for the byte-level token piece decoder.
package blpd_pkg;

  localparam int MAX_OUT = 4;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int IDX_W   = $clog2(MAX_OUT);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [MAX_OUT-1:0] bytes;
    logic [IDX_W-1:0]    last_idx;
    logic                piece_end;
  } blpd_group_t;

  typedef struct packed {
    logic        valid;
    blpd_group_t group;
  } blpd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } blpd_qstat_t;

endpackage

FILE: rtl/core/blpd_if.sv
// Handshake interfaces for the token piece input and the raw byte output.
interface blpd_in_if;
  logic               valid;
  logic               ready;
  blpd_pkg::byte_t    in_byte;
  logic               token_end;

  modport source (output valid, output in_byte, output token_end, input ready);
  modport sink (input valid, input in_byte, input token_end, output ready);
endinterface

interface blpd_out_if;
  logic               valid;
  logic               ready;
  blpd_pkg::byte_t    out_byte;
  logic               run_last;
  logic               piece_last;

  modport source (output valid, output out_byte, output run_last, output piece_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input piece_last,
                output ready);
endinterface

FILE: rtl/core/blpd_front.sv
// Front end: accepts bytes, buffers partial UTF-8 sequences and forms result groups.
module blpd_front (
  input  logic                  clk,
  input  logic                  rst,
  blpd_in_if.sink               piece,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  blpd_pkg::blpd_qstat_t qstat,
  output blpd_pkg::blpd_push_t  push
);

  logic                              decode_enable;
  blpd_pkg::byte_t [2:0]             pend;
  logic [1:0]                        pcount;
  blpd_pkg::byte_t [2:0]             pend_next;
  logic [1:0]                        pcount_next;
  blpd_pkg::byte_t [3:0]             obuf;
  logic [2:0]                        k;
  logic                              accept;

  function automatic logic [2:0] lead_length(input blpd_pkg::byte_t lead);
    logic [2:0] len;
    if (lead[7] == 1'b0) len = 3'd1;
    else if (lead[7:5] == 3'b110) len = 3'd2;
    else if (lead[7:4] == 4'b1110) len = 3'd3;
    else if (lead[7:3] == 5'b11110) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic [8:0] map_cp(input logic [20:0] cp);
    logic [8:0] res;
    logic [7:0] lo;
    lo = cp[7:0];
    if (cp <= 21'd255) begin
      res = {((lo >= 8'd33) && (lo <= 8'd126)) || ((lo >= 8'd161) && (lo <= 8'd172)) ||
             (lo >= 8'd174), lo};
    end else if (cp <= 21'd288) begin
      res = {1'b1, lo};
    end else if (cp <= 21'd322) begin
      res = {1'b1, 8'(cp[8:0] - 9'd162)};
    end else if (cp == 21'd323) begin
      res = {1'b1, 8'd173};
    end else begin
      res = 9'd0;
    end
    return res;
  endfunction

  always_comb begin
    blpd_pkg::byte_t [3:0] wbuf;
    logic [2:0]            cnt;
    logic [2:0]            len;
    logic [2:0]            have;
    logic [2:0]            drop;
    logic                  bad;
    logic                  stop;
    logic [20:0]           cp;
    logic [8:0]            hit;
    wbuf = '0;
    for (int i = 0; i < 3; i++) wbuf[i] = pend[i];
    wbuf[pcount] = piece.in_byte;
    cnt = {1'b0, pcount} + 3'd1;
    obuf = '0;
    k = 3'd0;
    stop = 1'b0;
    len = 3'd0;
    have = 3'd0;
    drop = 3'd0;
    bad = 1'b0;
    cp = '0;
    hit = '0;
    if (!decode_enable) begin
      obuf = wbuf;
      k = cnt;
      cnt = 3'd0;
      wbuf = '0;
    end else begin
      for (int it = 0; it < 4; it++) begin
        if (!stop && cnt != 3'd0) begin
          len = lead_length(wbuf[0]);
          have = (cnt < len) ? cnt : len;
          bad = 1'b0;
          for (int j = 1; j < 4; j++) begin
            if ((3'(j) < have) && (wbuf[j][7:6] != 2'b10)) bad = 1'b1;
          end
          drop = 3'd0;
          cp = '0;
          hit = '0;
          if (len == 3'd0 || bad || (cnt < len && piece.token_end)) begin
            obuf[k[1:0]] = wbuf[0];
            k = k + 3'd1;
            drop = 3'd1;
          end else if (cnt < len) begin
            stop = 1'b1;
          end else begin
            case (len)
              3'd1: cp = {13'd0, wbuf[0]};
              3'd2: cp = {10'd0, wbuf[0][4:0], wbuf[1][5:0]};
              3'd3: cp = {5'd0, wbuf[0][3:0], wbuf[1][5:0], wbuf[2][5:0]};
              default: cp = {wbuf[0][2:0], wbuf[1][5:0], wbuf[2][5:0], wbuf[3][5:0]};
            endcase
            hit = map_cp(cp);
            if (hit[8]) begin
              obuf[k[1:0]] = hit[7:0];
              k = k + 3'd1;
            end else begin
              for (int j = 0; j < 4; j++) begin
                if (3'(j) < len) obuf[2'(k + 3'(j))] = wbuf[j];
              end
              k = k + len;
            end
            drop = len;
          end
          wbuf = wbuf >> {drop, 3'b000};
          cnt = cnt - drop;
        end
      end
    end
    for (int i = 0; i < 3; i++) pend_next[i] = wbuf[i];
    pcount_next = cnt[1:0];
  end

  assign accept = piece.valid && piece.ready;
  assign piece.ready = !qstat.full;

  always_comb begin
    push.valid = accept && (k != 3'd0);
    push.group.bytes = obuf;
    push.group.last_idx = 2'(k - 3'd1);
    push.group.piece_end = piece.token_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b1;
      pend <= '0;
      pcount <= 2'd0;
    end else begin
      if (cfg_we) decode_enable <= cfg_wdata;
      if (accept) begin
        pend <= pend_next;
        pcount <= pcount_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && piece.token_end |=> pcount == 2'd0)
    else $error("Buffered bytes survive the end of a token piece.");
`endif

endmodule

FILE: rtl/core/blpd_queue.sv
// Short queue of result groups between the front end and the back end.
module blpd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  blpd_pkg::blpd_push_t   push,
  input  logic                   pop,
  output blpd_pkg::blpd_group_t  head,
  output blpd_pkg::blpd_qstat_t  stat
);

  blpd_pkg::blpd_group_t [blpd_pkg::QDEPTH-1:0] mem;
  logic [blpd_pkg::QPTR_W-1:0]                  wptr;
  logic [blpd_pkg::QPTR_W-1:0]                  rptr;
  logic [blpd_pkg::QCNT_W-1:0]                  count;

  assign head = mem[rptr];
  assign stat.full = (count == blpd_pkg::QCNT_W'(blpd_pkg::QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push.valid) mem[wptr] <= push.group;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push.valid) wptr <= wptr + blpd_pkg::QPTR_W'(1);
      if (pop) rptr <= rptr + blpd_pkg::QPTR_W'(1);
      case ({push.valid, pop})
        2'b10: count <= count + blpd_pkg::QCNT_W'(1);
        2'b01: count <= count - blpd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !stat.full)
    else $error("Group written into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("Group taken from an empty queue.");
`endif

endmodule

FILE: rtl/core/blpd_back.sv
// Back end: sends queued bytes one item per cycle while raw.ready is set.
module blpd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  blpd_pkg::blpd_group_t head,
  input  blpd_pkg::blpd_qstat_t stat,
  output logic                  pop,
  blpd_out_if.source            raw
);

  logic [blpd_pkg::IDX_W-1:0] idx;
  logic                       valid;
  blpd_pkg::byte_t            out_byte;
  logic                       run_last;
  logic                       piece_last;
  logic                       load;
  logic                       last;

  assign last = (idx == head.last_idx);
  assign load = !stat.empty && (!valid || raw.ready);
  assign pop = load && last;

  assign raw.valid = valid;
  assign raw.out_byte = out_byte;
  assign raw.run_last = run_last;
  assign raw.piece_last = piece_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx <= last ? '0 : idx + blpd_pkg::IDX_W'(1);
      end else if (raw.ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      run_last <= last;
      piece_last <= last && head.piece_end;
    end
  end

`ifndef SYNTHESIS
  a_idx_has_group: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> !stat.empty)
    else $error("Partly sent group is missing from the queue.");
  a_piece_on_run: assert property (@(posedge clk) disable iff (rst)
    valid && piece_last |-> run_last)
    else $error("End of piece marked on an item that does not end its run.");
`endif

endmodule

FILE: rtl/core/byte_level_token_piece_decoder.sv
// Top level of the byte-level token piece decoder.
// The piece channel takes one UTF-8 byte of a token piece per item, with
// token_end set on the final byte of the piece. The raw channel returns the
// decoded bytes, zero to four items for each input item; run_last marks the
// last item caused by one input item and piece_last marks the last item of a
// token piece. The decode_enable register is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce this; zero passes bytes through unchanged. An
// input item is resolved in the cycle it is accepted; its results are
// registered in the group queue, then in the output register. Input items
// are taken at one per cycle while the queue is not full, and the output
// sends one item per cycle while the receiver is ready, so the rate is set
// by the raw byte count. A four-entry group queue between the parser and
// the output register absorbs bursts. When the receiver stalls, the output
// item holds and the queue fills, after which the piece channel drops ready.
// Reset empties the queue and sequence buffer and sets decode_enable to one.
module byte_level_token_piece_decoder (
  input  logic       clk,
  input  logic       rst,
  blpd_in_if.sink    piece,
  blpd_out_if.source raw,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  blpd_pkg::blpd_push_t  push;
  blpd_pkg::blpd_group_t head;
  blpd_pkg::blpd_qstat_t qstat;
  logic                  pop;

  blpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .piece     (piece),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .push      (push)
  );

  blpd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  blpd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .stat (qstat),
    .pop  (pop),
    .raw  (raw)
  );

endmodule

FILE: test/raw_byte_checker.sv
// Watches the piece and raw channels, predicts the decoded bytes and compares them.
`timescale 1ns / 100ps
module raw_byte_checker (
  input  logic clk,
  input  logic rst,
  blpd_in_if   piece,
  blpd_out_if  raw,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatch_count,
  output int   raw_backlog
);

  typedef struct packed {
    blpd_pkg::byte_t data;
    logic            run_last;
    logic            piece_last;
  } raw_item_t;

  raw_item_t       expected_raw[$];
  logic            decode_on;
  blpd_pkg::byte_t held_bytes[3];
  int              held_count;
  int              errors = 0;

  function automatic int seq_length(blpd_pkg::byte_t lead);
    if (lead[7] == 1'b0) return 1;
    if (lead[7:5] == 3'b110) return 2;
    if (lead[7:4] == 4'b1110) return 3;
    if (lead[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic bit to_raw(int unsigned cp, output blpd_pkg::byte_t value);
    value = 8'h00;
    if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) || (cp >= 174 && cp <= 255)) begin
      value = cp[7:0];
      return 1'b1;
    end
    if (cp >= 256 && cp <= 288) begin
      value = 8'(cp - 256);
      return 1'b1;
    end
    if (cp >= 289 && cp <= 322) begin
      value = 8'(cp - 289 + 127);
      return 1'b1;
    end
    if (cp == 323) begin
      value = 8'd173;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic decode_piece_byte(blpd_pkg::byte_t in_byte, logic token_end);
    blpd_pkg::byte_t seq [4];
    blpd_pkg::byte_t outs [8];
    int              head;
    int              cnt;
    int              len;
    int              have;
    int              n_out;
    logic            bad;
    int unsigned     cp;
    blpd_pkg::byte_t mapped;
    raw_item_t       item;
    seq[0] = held_bytes[0];
    seq[1] = held_bytes[1];
    seq[2] = held_bytes[2];
    seq[3] = 8'h00;
    cnt = held_count;
    seq[cnt] = in_byte;
    cnt++;
    head = 0;
    n_out = 0;
    if (!decode_on) begin
      for (int i = 0; i < cnt; i++) begin
        outs[n_out] = seq[i];
        n_out++;
      end
      cnt = 0;
    end else begin
      while (cnt > 0) begin
        len = seq_length(seq[head]);
        if (len == 0) begin
          outs[n_out] = seq[head];
          n_out++;
          head++;
          cnt--;
          continue;
        end
        have = (cnt < len) ? cnt : len;
        bad = 1'b0;
        for (int j = 1; j < have; j++) begin
          if (seq[head + j][7:6] != 2'b10) bad = 1'b1;
        end
        if (bad || (cnt < len && token_end)) begin
          outs[n_out] = seq[head];
          n_out++;
          head++;
          cnt--;
          continue;
        end
        if (cnt < len) break;
        case (len)
          1: cp = seq[head];
          2: cp = seq[head] & 8'h1F;
          3: cp = seq[head] & 8'h0F;
          default: cp = seq[head] & 8'h07;
        endcase
        for (int j = 1; j < len; j++) cp = (cp << 6) | (seq[head + j] & 8'h3F);
        if (to_raw(cp, mapped)) begin
          outs[n_out] = mapped;
          n_out++;
        end else begin
          for (int j = 0; j < len; j++) begin
            outs[n_out] = seq[head + j];
            n_out++;
          end
        end
        head += len;
        cnt -= len;
      end
    end
    for (int i = 0; i < n_out; i++) begin
      item.data = outs[i];
      item.run_last = (i == n_out - 1);
      item.piece_last = (i == n_out - 1) && token_end;
      expected_raw.insert(expected_raw.size(), item);
    end
    for (int i = 0; i < 3; i++) held_bytes[i] = (i < cnt) ? seq[head + i] : 8'h00;
    held_count = cnt;
  endtask

  always @(posedge clk) begin
    raw_item_t want;
    if (rst) begin
      decode_on = 1'b1;
      for (int i = 0; i < 3; i++) held_bytes[i] = 8'h00;
      held_count = 0;
      expected_raw.delete();
    end else begin
      if (piece.valid && piece.ready) decode_piece_byte(piece.in_byte, piece.token_end);
      if (cfg_we) decode_on = cfg_wdata;
      if (raw.valid && raw.ready) begin
        if (expected_raw.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected raw item: byte %02h run_last %0b piece_last %0b",
                     raw.out_byte, raw.run_last, raw.piece_last);
          end
        end else begin
          want = expected_raw.pop_front();
          if (want.data !== raw.out_byte || want.run_last !== raw.run_last ||
              want.piece_last !== raw.piece_last) begin
            errors++;
            if (errors <= 10) begin
              $display("raw item mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       want.data, want.run_last, want.piece_last,
                       raw.out_byte, raw.run_last, raw.piece_last);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    raw_backlog <= expected_raw.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int ITEM_TARGET = 410;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatch_count;
  int   raw_backlog;
  int   cycle_count;
  int   items_sent;
  int   burst_left;
  bit   steady_feed;
  bit   long_hold_req;

  blpd_in_if  piece_if();
  blpd_out_if raw_if();

  byte_level_token_piece_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .piece     (piece_if),
    .raw       (raw_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  raw_byte_checker raw_check (
    .clk            (clk),
    .rst            (rst),
    .piece          (piece_if),
    .raw            (raw_if),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .raw_backlog    (raw_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int hold_left;
    int seg_left;
    int mode;
    int tick;
    bit hold_done;
    raw_if.ready = 1'b0;
    hold_left = 0;
    seg_left = 0;
    mode = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(16, 80);
      end
      seg_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        raw_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: raw_if.ready <= 1'b1;
          1: raw_if.ready <= ($urandom_range(0, 1) == 1);
          2: raw_if.ready <= ($urandom_range(0, 7) != 0);
          default: raw_if.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_byte(blpd_pkg::byte_t b, logic te);
    if (!steady_feed && burst_left == 0) begin
      piece_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    piece_if.valid <= 1'b1;
    piece_if.in_byte <= b;
    piece_if.token_end <= te;
    do @(posedge clk); while (piece_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_seq(logic [31:0] bytes, int n, logic te_last);
    for (int k = 0; k < n; k++) send_byte(bytes[8*k +: 8], te_last && (k == n - 1));
  endtask

  function automatic logic [31:0] utf8_pack(int unsigned cp, int len);
    case (len)
      1: return {24'h0, cp[7:0]};
      2: return {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      3: return {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    endcase
  endfunction

  task automatic send_random_piece();
    int              n_cp;
    int              kind;
    int              len;
    int              n;
    int              pos;
    int unsigned     cp;
    logic [31:0]     enc;
    blpd_pkg::byte_t junk;
    n_cp = $urandom_range(1, 5);
    for (int c = 0; c < n_cp; c++) begin
      kind = $urandom_range(0, 19);
      len = 1;
      cp = 0;
      case (kind)
        0, 1, 2, 3, 4, 5: cp = $urandom_range(33, 126);
        6, 7, 8, 9: begin
          cp = $urandom_range(256, 323);
          len = 2;
        end
        10: begin
          cp = $urandom_range(128, 255);
          len = 2;
        end
        11: begin
          cp = $urandom_range(0, 32'h7FF);
          len = 2;
        end
        12, 13: begin
          cp = $urandom_range(0, 32'hFFFF);
          len = 3;
        end
        14: begin
          cp = $urandom_range(0, 32'h1FFFFF);
          len = 4;
        end
        15: cp = $urandom_range(0, 255);
        16: cp = $urandom_range(0, 127);
        19: cp = $urandom_range(128, 255);
        default: begin
          len = $urandom_range(2, 4);
          cp = $urandom_range(0, 32'h1FFFFF);
        end
      endcase
      enc = utf8_pack(cp, len);
      n = len;
      if (kind == 17) begin
        n = $urandom_range(1, len - 1);
      end else if (kind == 18) begin
        pos = $urandom_range(1, len - 1);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        enc[8*pos +: 8] = junk;
      end
      send_seq(enc, n, c == n_cp - 1);
    end
  endtask

  task automatic send_random_until(int target);
    while (items_sent < target) send_random_piece();
  endtask

  task automatic wait_idle();
    piece_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (raw_backlog != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_decode(logic v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    piece_if.valid = 1'b0;
    piece_if.in_byte = 8'h00;
    piece_if.token_end = 1'b0;
    items_sent = 0;
    burst_left = 0;
    steady_feed = 1'b0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_decode(1'b1);
    send_seq(32'h41, 1, 1'b1);
    send_seq(32'h80C4, 2, 1'b1);
    send_seq(32'h83C5, 2, 1'b1);
    send_seq(32'hADC2, 2, 1'b1);
    send_seq(32'hAC82E2, 3, 1'b1);
    send_seq(32'h80989FF0, 4, 1'b1);
    send_seq(32'hFF, 1, 1'b0);
    send_seq(32'h41C3, 2, 1'b1);
    send_seq(32'h80E0, 2, 1'b1);
    send_seq(32'h00, 1, 1'b1);
    send_seq(32'hBFC1, 2, 1'b1);
    send_seq(32'h80A0ED, 3, 1'b1);

    // A lead byte left in the buffer must come out raw once decoding is off.
    send_seq(32'hC3, 1, 1'b0);
    write_decode(1'b0);
    send_seq(32'hBF41, 2, 1'b1);
    send_random_until(items_sent + 60);

    write_decode(1'b1);
    send_seq(32'hE2, 1, 1'b0);
    write_decode(1'b1);
    send_seq(32'hAC82, 2, 1'b1);
    send_random_until(items_sent + 170);

    steady_feed = 1'b1;
    long_hold_req <= 1'b1;
    send_random_until(items_sent + 60);
    steady_feed = 1'b0;

    write_decode(1'b0);
    send_random_until(items_sent + 30);
    write_decode(1'b1);
    send_random_until(ITEM_TARGET);

    wait_idle();
    if (mismatch_count == 0 && raw_backlog == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
